// ===== design/jsu_pkg.sv =====
package jsu_pkg;

  // Result kinds
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_END    = 2'd1;
  localparam logic [1:0] KIND_BADESC = 2'd2;
  localparam logic [1:0] KIND_BADHEX = 2'd3;

  // Queue between decoder and serialiser
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  // One decoded input byte: up to three result beats
  typedef struct packed {
    logic [1:0]      cnt;   // number of beats, 1 to 3
    logic [1:0]      kind;
    logic [2:0][7:0] data;  // data[0] goes out first
  } jsu_entry_t;

endpackage

// ===== design/json_string_unescape.sv =====
// JSON string body decoder.
// Input channel (in_valid / in_stall / in_byte): one raw byte of the string
// body per beat, starting after the opening quote. Output channel
// (out_valid / out_stall / out_byte, kind, last): one result per beat.
// kind 0 is a data byte, 1 the closing quote, 2 a bad escape letter and
// 3 a bad hex digit inside \u; last marks the final beat of one input byte.
// Backslashes and hex digits that do not complete an escape, and \u0000,
// give no beat at all.
// A result passes two registers: the edge that takes its input beat writes
// the decoded entry into the queue, and a later one loads it into the
// output register, from which the result is offered.
// Throughput: one input beat per cycle; the output side gives one beat per
// cycle while out_stall is low, so a \u escape yielding two or three UTF-8
// bytes holds the serialiser for a beat per byte. A four-entry queue
// between decoder and serialiser absorbs them; in_stall rises only when full.
// Reset (rst, synchronous) returns to plain text mode, clears the hex
// accumulator, empties the queue and drops out_valid.
// When the receiver stalls, the output beat holds; the decoder keeps taking
// bytes until the queue fills.
module json_string_unescape (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] kind,
  output logic       last
);
  import jsu_pkg::*;

  // Decoder to queue
  logic       push;
  jsu_entry_t push_entry;
  logic       q_full;

  // Queue to serialiser
  jsu_entry_t head;
  logic       q_empty;
  logic       pop;

  // Front: escape state machine, hex accumulator and UTF-8 encoding
  jsu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .push       (push),
    .push_entry (push_entry),
    .q_full     (q_full)
  );

  // Hold decoded entries while the output side drains
  jsu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty)
  );

  // Back: split each entry into beats behind an output register
  jsu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .kind      (kind),
    .last      (last)
  );

endmodule

// ===== design/jsu_front.sv =====
module jsu_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_byte,
  output logic               push,
  output jsu_pkg::jsu_entry_t push_entry,
  input  logic               q_full
);
  import jsu_pkg::*;

  typedef enum logic [5:0] {
    M_PLAIN = 6'b000001,
    M_ESC   = 6'b000010,
    M_HEX1  = 6'b000100,
    M_HEX2  = 6'b001000,
    M_HEX3  = 6'b010000,
    M_HEX4  = 6'b100000
  } mode_t;

  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  mode_t       mode, mode_next;
  logic [15:0] hex_value, hex_next;
  logic        accept;
  logic        dvalid;
  logic [3:0]  dval;
  logic [15:0] h;
  jsu_entry_t  e;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Hex digit of either case
  always_comb begin
    dvalid = 1'b1;
    dval   = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      dval = in_byte[3:0];
    end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
      dval = 4'd9 + {1'b0, in_byte[2:0]};
    end else begin
      dvalid = 1'b0;
    end
  end

  assign h = {hex_value[11:0], dval};

  always_comb begin
    mode_next = mode;
    hex_next  = hex_value;
    e         = '0;
    unique case (mode)
      M_ESC: begin
        mode_next = M_PLAIN;
        e.cnt     = 2'd1;
        e.kind    = KIND_DATA;
        case (in_byte)
          CH_BSLASH, CH_QUOTE, CH_SLASH: e.data[0] = in_byte;
          CH_B: e.data[0] = 8'h08;
          CH_F: e.data[0] = 8'h0c;
          CH_N: e.data[0] = 8'h0a;
          CH_R: e.data[0] = 8'h0d;
          CH_T: e.data[0] = 8'h09;
          CH_U: begin
            mode_next = M_HEX1;
            hex_next  = 16'd0;
            e.cnt     = 2'd0;
          end
          default: e.kind = KIND_BADESC;
        endcase
      end
      M_HEX1, M_HEX2, M_HEX3, M_HEX4: begin
        if (!dvalid) begin
          mode_next = M_PLAIN;
          hex_next  = 16'd0;
          e.cnt     = 2'd1;
          e.kind    = KIND_BADHEX;
        end else begin
          hex_next = h;
          if (mode != M_HEX4) begin
            mode_next = mode_t'({mode[4:0], 1'b0});
          end else begin
            mode_next = M_PLAIN;
            e.kind    = KIND_DATA;
            if (h == 16'd0) begin
              e.cnt = 2'd0;
            end else if (h < 16'h0080) begin
              e.cnt     = 2'd1;
              e.data[0] = h[7:0];
            end else if (h < 16'h0800) begin
              e.cnt     = 2'd2;
              e.data[0] = 8'hc0 | {3'b000, h[10:6]};
              e.data[1] = 8'h80 | {2'b00, h[5:0]};
            end else begin
              e.cnt     = 2'd3;
              e.data[0] = 8'he0 | {4'b0000, h[15:12]};
              e.data[1] = 8'h80 | {2'b00, h[11:6]};
              e.data[2] = 8'h80 | {2'b00, h[5:0]};
            end
          end
        end
      end
      default: begin
        mode_next = M_PLAIN;
        if (in_byte == CH_BSLASH) begin
          mode_next = M_ESC;
        end else if (in_byte == CH_QUOTE) begin
          hex_next = 16'd0;
          e.cnt    = 2'd1;
          e.kind   = KIND_END;
        end else begin
          e.cnt     = 2'd1;
          e.kind    = KIND_DATA;
          e.data[0] = in_byte;
        end
      end
    endcase
  end

  assign push       = accept && (e.cnt != 2'd0);
  assign push_entry = e;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_PLAIN;
      hex_value <= 16'd0;
    end else if (accept) begin
      mode      <= mode_next;
      hex_value <= hex_next;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("push into full queue");
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    push && (push_entry.kind != KIND_DATA) |-> push_entry.cnt == 2'd1)
    else $error("error or end entry with several beats");
  a_mode_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(mode))
    else $error("escape mode not one-hot");

endmodule

// ===== design/jsu_queue.sv =====
module jsu_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  jsu_pkg::jsu_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output jsu_pkg::jsu_entry_t head,
  output logic                empty
);
  import jsu_pkg::*;

  jsu_entry_t     mem [QDEPTH];
  logic [QAW-1:0] wptr, rptr;
  logic [QCW-1:0] count;

  assign full  = (count == QCW'(QDEPTH));
  assign empty = (count == '0);
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCW'(QDEPTH))
    else $error("queue count beyond depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");
  a_full_empty: assert property (@(posedge clk) disable iff (rst) !(full && empty))
    else $error("queue both full and empty");

endmodule

// ===== design/jsu_back.sv =====
module jsu_back (
  input  logic                clk,
  input  logic                rst,
  input  jsu_pkg::jsu_entry_t head,
  input  logic                q_empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic [1:0]          kind,
  output logic                last
);
  import jsu_pkg::*;

  logic [1:0] idx;
  logic       load, take, is_last;
  logic [7:0] sel;

  assign load    = !out_valid || !out_stall;
  assign take    = load && !q_empty;
  assign is_last = (idx == 2'(head.cnt - 2'd1));
  assign pop     = take && is_last;

  always_comb begin
    case (idx)
      2'd0:    sel = head.data[0];
      2'd1:    sel = head.data[1];
      default: sel = head.data[2];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      out_valid <= !q_empty;
      if (take) begin
        idx <= is_last ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte <= sel;
      kind     <= head.kind;
      last     <= is_last;
    end
  end

  a_idx_in_entry: assert property (@(posedge clk) disable iff (rst)
    !q_empty |-> idx < head.cnt)
    else $error("beat index past entry");
  a_idx_idle: assert property (@(posedge clk) disable iff (rst) q_empty |-> idx == 2'd0)
    else $error("beat index not reset with empty queue");
  a_nondata_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != KIND_DATA) |-> last && (out_byte == 8'd0))
    else $error("end or error beat malformed");

endmodule

// ===== bench/json_string_unescape_tb.sv =====
module json_string_unescape_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jsu_pkg::*;

  // Raw characters that steer the escape decoder
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  // Every letter that forms a one-byte escape after a backslash
  localparam logic [7:0][7:0] ESC_LETTERS =
    {CH_BSLASH, CH_QUOTE, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};

  // Decoder modes: plain text, after a backslash, awaiting hex digit 1..4
  localparam logic [2:0] ST_PLAIN = 3'd0;
  localparam logic [2:0] ST_ESC   = 3'd1;
  localparam logic [2:0] ST_HEX1  = 3'd2;
  localparam logic [2:0] ST_HEX2  = 3'd3;
  localparam logic [2:0] ST_HEX3  = 3'd4;
  localparam logic [2:0] ST_HEX4  = 3'd5;

  localparam int RANDOM_ITEMS = 242;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       last;
  } unesc_beat_t;

  // One row of the directed table. Where typed is set, the row carries its
  // own expectation (no beat, or one beat of the given kind and data);
  // otherwise the decoder model below supplies it.
  typedef struct packed {
    logic [7:0] raw;
    logic       typed;
    logic       has_beat;
    logic [1:0] kind;
    logic [7:0] data;
  } dir_row_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       last;

  // Decoder model state
  logic [2:0]  esc_state;
  logic [15:0] hex_acc;

  unesc_beat_t fresh_beats[$];    // beats caused by the byte just taken
  unesc_beat_t awaited_beats[$];  // beats still owed by the block, oldest first

  int items_sent = 0;
  int mismatches = 0;
  bit in_idle_on = 1'b1;
  bit out_stall_on = 1'b1;

  dir_row_t dir_rows [28] = '{
    // plain zero and the top byte pass straight through
    {8'h00,     1'b1, 1'b1, KIND_DATA,   8'h00},
    {8'hff,     1'b1, 1'b1, KIND_DATA,   8'hff},
    // unescaped quote closes the string
    {CH_QUOTE,  1'b1, 1'b1, KIND_END,    8'h00},
    // escaped quote is data and leaves the string open
    {CH_BSLASH, 1'b1, 1'b0, KIND_DATA,   8'h00},
    {CH_QUOTE,  1'b1, 1'b1, KIND_DATA,   8'h22},
    // unknown escape letter
    {CH_BSLASH, 1'b1, 1'b0, KIND_DATA,   8'h00},
    {"q",       1'b1, 1'b1, KIND_BADESC, 8'h00},
    // highest code point, digits in mixed case: three UTF-8 bytes
    {CH_BSLASH, 1'b1, 1'b0, KIND_DATA,   8'h00},
    {CH_U,      1'b1, 1'b0, KIND_DATA,   8'h00},
    {"F",       1'b1, 1'b0, KIND_DATA,   8'h00},
    {"f",       1'b1, 1'b0, KIND_DATA,   8'h00},
    {"F",       1'b1, 1'b0, KIND_DATA,   8'h00},
    {"f",       1'b0, 1'b0, KIND_DATA,   8'h00},
    // a zero code point gives nothing at all
    {CH_BSLASH, 1'b1, 1'b0, KIND_DATA,   8'h00},
    {CH_U,      1'b1, 1'b0, KIND_DATA,   8'h00},
    {"0",       1'b1, 1'b0, KIND_DATA,   8'h00},
    {"0",       1'b1, 1'b0, KIND_DATA,   8'h00},
    {"0",       1'b1, 1'b0, KIND_DATA,   8'h00},
    {"0",       1'b1, 1'b0, KIND_DATA,   8'h00},
    // top of the two-byte range
    {CH_BSLASH, 1'b1, 1'b0, KIND_DATA,   8'h00},
    {CH_U,      1'b1, 1'b0, KIND_DATA,   8'h00},
    {"0",       1'b1, 1'b0, KIND_DATA,   8'h00},
    {"7",       1'b1, 1'b0, KIND_DATA,   8'h00},
    {"F",       1'b1, 1'b0, KIND_DATA,   8'h00},
    {"f",       1'b0, 1'b0, KIND_DATA,   8'h00},
    // non-hex byte inside a unicode escape
    {CH_BSLASH, 1'b1, 1'b0, KIND_DATA,   8'h00},
    {CH_U,      1'b1, 1'b0, KIND_DATA,   8'h00},
    {"g",       1'b1, 1'b1, KIND_BADHEX, 8'h00}
  };

  json_string_unescape dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .kind      (kind),
    .last      (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bit 4 flags a byte that is not a hex digit; bits 3:0 hold its value.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
    if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      return {1'b0, c[3:0] + 4'd9};
    return 5'h10;
  endfunction

  function automatic void add_beat(input logic [7:0] data, input logic [1:0] k);
    fresh_beats.push_back({data, k, 1'b0});
  endfunction

  // Advance the decoder model by one raw byte and collect what it gives.
  task automatic decode_byte(input logic [7:0] c);
    logic [4:0]  nib;
    logic [15:0] acc;
    fresh_beats.delete();
    case (esc_state)
      ST_ESC: begin
        esc_state = ST_PLAIN;
        case (c)
          CH_BSLASH, CH_QUOTE, CH_SLASH: add_beat(c, KIND_DATA);
          CH_B: add_beat(8'h08, KIND_DATA);
          CH_F: add_beat(8'h0c, KIND_DATA);
          CH_N: add_beat(8'h0a, KIND_DATA);
          CH_R: add_beat(8'h0d, KIND_DATA);
          CH_T: add_beat(8'h09, KIND_DATA);
          CH_U: begin
            esc_state = ST_HEX1;
            hex_acc   = '0;
          end
          default: add_beat(8'h00, KIND_BADESC);
        endcase
      end
      ST_HEX1, ST_HEX2, ST_HEX3, ST_HEX4: begin
        nib = hex_nibble(c);
        if (nib[4]) begin
          // bad digit: drop the escape and clear the accumulator
          esc_state = ST_PLAIN;
          hex_acc   = '0;
          add_beat(8'h00, KIND_BADHEX);
        end else begin
          acc     = {hex_acc[11:0], nib[3:0]};
          hex_acc = acc;
          if (esc_state != ST_HEX4) begin
            esc_state = esc_state + 3'd1;
          end else begin
            esc_state = ST_PLAIN;
            if (acc == 16'h0000) begin
              // a zero code point is swallowed
            end else if (acc < 16'h0080) begin
              add_beat(acc[7:0], KIND_DATA);
            end else if (acc < 16'h0800) begin
              add_beat({3'b110, acc[10:6]}, KIND_DATA);
              add_beat({2'b10, acc[5:0]}, KIND_DATA);
            end else begin
              add_beat({4'b1110, acc[15:12]}, KIND_DATA);
              add_beat({2'b10, acc[11:6]}, KIND_DATA);
              add_beat({2'b10, acc[5:0]}, KIND_DATA);
            end
          end
        end
      end
      default: begin
        // plain text; the unused mode codes behave the same way
        esc_state = ST_PLAIN;
        if (c == CH_BSLASH) begin
          esc_state = ST_ESC;
        end else if (c == CH_QUOTE) begin
          hex_acc = '0;
          add_beat(8'h00, KIND_END);
        end else begin
          add_beat(c, KIND_DATA);
        end
      end
    endcase
    if (fresh_beats.size() > 0) fresh_beats[fresh_beats.size() - 1].last = 1'b1;
  endtask

  // Offer one input beat, wait for the block to take it, then book what it
  // owes. Entered and left just after a falling edge.
  task automatic send_beat(input dir_row_t row);
    while (in_idle_on && $urandom_range(0, 99) < 18) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= row.raw;
    do @(posedge clk); while (in_stall);
    decode_byte(row.raw);
    if (row.typed) begin
      if (row.has_beat) awaited_beats.push_back({row.data, row.kind, 1'b1});
    end else begin
      foreach (fresh_beats[k]) awaited_beats.push_back(fresh_beats[k]);
    end
    items_sent++;
    @(negedge clk);
  endtask

  // Build one random token (mostly well-formed, some broken, some noise)
  // and send its bytes.
  task automatic send_token();
    logic [7:0]  seq[$];
    dir_row_t    row;
    int          pick;
    int          ndig;
    logic [15:0] val;
    logic [7:0]  c;
    logic [3:0]  nib;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      // ordinary text byte
      do c = 8'($urandom_range(0, 255)); while (c == CH_BSLASH || c == CH_QUOTE);
      seq.push_back(c);
    end else if (pick < 45) begin
      seq.push_back(CH_QUOTE);
    end else if (pick < 65) begin
      seq.push_back(CH_BSLASH);
      seq.push_back(ESC_LETTERS[3'($urandom_range(0, 7))]);
    end else if (pick < 85) begin
      // unicode escape: spread the value over every output length
      case ($urandom_range(0, 9))
        0:       val = 16'h0000;
        1, 2, 3: val = 16'($urandom_range(16'h0001, 16'h007f));
        4, 5, 6: val = 16'($urandom_range(16'h0080, 16'h07ff));
        default: val = 16'($urandom_range(16'h0800, 16'hffff));
      endcase
      seq.push_back(CH_BSLASH);
      seq.push_back(CH_U);
      for (int i = 3; i >= 0; i--) begin
        nib = val[i * 4 +: 4];
        // digits 0-9, letters in either case
        if (nib < 4'd10) c = 8'h30 + nib;
        else c = (($urandom_range(0, 1) != 0) ? 8'h61 : 8'h41) + nib - 8'd10;
        seq.push_back(c);
      end
    end else if (pick < 95) begin
      seq.push_back(CH_BSLASH);
      if ($urandom_range(0, 1) != 0) begin
        // any byte after a backslash, valid letter or not
        seq.push_back(8'($urandom_range(0, 255)));
      end else begin
        // unicode escape cut short by a non-hex byte
        seq.push_back(CH_U);
        ndig = $urandom_range(0, 3);
        repeat (ndig) begin
          do c = 8'($urandom_range(0, 255)); while (hex_nibble(c) == 5'h10);
          seq.push_back(c);
        end
        do c = 8'($urandom_range(0, 255)); while (hex_nibble(c) != 5'h10);
        seq.push_back(c);
      end
    end else begin
      seq.push_back(8'($urandom_range(0, 255)));
    end
    row = '0;
    foreach (seq[k]) begin
      row.raw = seq[k];
      send_beat(row);
    end
  endtask

  // Receiver: stall at random, changing only on the falling edge.
  always @(negedge clk) begin
    out_stall <= out_stall_on && ($urandom_range(0, 99) < 18);
  end

  // Check each result beat taken at the rising edge against the oldest one owed.
  always @(posedge clk) begin : check_beats
    unesc_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_beats.size() == 0) begin
        $error("result beat with none owed: out_byte %h kind %0d last %0b",
               out_byte, kind, last);
        mismatches++;
      end else begin
        want = awaited_beats.pop_front();
        if (out_byte !== want.data) begin
          $error("out_byte: expected %h, got %h", want.data, out_byte);
          mismatches++;
        end
        if (kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind);
          mismatches++;
        end
        if (last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_byte   = 8'h00;
    esc_state = ST_PLAIN;
    hex_acc   = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table first: extremes, escapes, the unicode corner cases
    foreach (dir_rows[i]) send_beat(dir_rows[i]);

    // Random tokens; a quiet stretch in the middle runs both sides flat out,
    // and in a later stretch each token waits until the block has drained.
    while (items_sent < $size(dir_rows) + RANDOM_ITEMS) begin
      in_idle_on   = !(items_sent >= 100 && items_sent < 170);
      out_stall_on = in_idle_on;
      if (items_sent >= 200 && items_sent < 205) begin
        in_valid <= 1'b0;
        wait (awaited_beats.size() == 0);
        @(negedge clk);
      end
      send_token();
    end

    // Drain, then let the clock run on for any stray beat to show up
    in_valid     <= 1'b0;
    out_stall_on = 1'b1;
    wait (awaited_beats.size() == 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
design/jsu_pkg.sv
design/jsu_front.sv
design/jsu_queue.sv
design/jsu_back.sv
design/json_string_unescape.sv
bench/json_string_unescape_tb.sv
